### src/spadd_pkg.sv
// Shared types and constants for the sparse polynomial add/subtract unit.
// Standalone package; used by every module in src but spadd_ram.
package spadd_pkg;

  localparam int MAX_TERMS  = 32;
  localparam int COEFF_BITS = 16;
  localparam int EXP_BITS   = 8;
  localparam int RES_BITS   = COEFF_BITS + 1;
  localparam int ENTRY_BITS = COEFF_BITS + EXP_BITS;

  typedef enum logic [1:0] {
    ACT_APPEND_FIRST  = 2'd0,
    ACT_APPEND_SECOND = 2'd1,
    ACT_COMBINE       = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]                   action;
    logic signed [COEFF_BITS-1:0] term_coeff;
    logic [EXP_BITS-1:0]          term_exponent;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_BITS-1:0] result_coeff;
    logic [EXP_BITS-1:0]        result_exponent;
    logic                       last_term;
  } out_item_t;

  // Merge engine status toward the load/control side.
  typedef struct packed {
    logic busy;
    logic done;
  } merge_stat_t;

endpackage

### src/sparse_polynomial_add_sub_unit.sv
// Top level of the sparse polynomial add/subtract unit: term loading, counts,
// mode register, two term RAMs and the merge engine. Depends on spadd_pkg,
// spadd_ram and spadd_merge.
//
//   channel   direction  handshake                payload
//   -------   ---------  -----------------------  ---------------------------
//   in        input      in_valid_i / in_stall_o   in_data_i  (in_item_t)
//   out       output     out_valid_o / out_stall_i out_data_o (out_item_t)
//   cfg       input      cfg_we_i                  cfg_wdata_i (subtract mode)
//
// An append transaction leaves the input open; the next one is taken in the cycle after.
// A combine transaction yields N result terms (N up to twice
// MAX_TERMS): the merge reads one head from each RAM per cycle, and the RAM read
// latency closes the loop from one head compare to the next read address.
// in_stall_o stays high from the cycle after a non-empty combine until its last term is
// registered; a stall on the output freezes the merge, holding both pointers.
// Reset clears the counts, the mode and the handshake state; RAM contents stay
// as they are and need no clearing pass, since only entries below the counts
// are ever used.
module sparse_polynomial_add_sub_unit #(
  parameter int MAX_TERMS = spadd_pkg::MAX_TERMS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  spadd_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output spadd_pkg::out_item_t out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i
);

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int EW = spadd_pkg::ENTRY_BITS;

  logic                   sub_mode_q, sub_mode_d;
  logic [CW-1:0]          cnt1_q, cnt1_d, cnt2_q, cnt2_d;
  logic                   in_fire, start, we1, we2;
  logic [EW-1:0]          wentry, rdata1, rdata2;
  logic [AW-1:0]          raddr1, raddr2;
  spadd_pkg::merge_stat_t stat;

  // Accept input only while the merge engine is idle.
  assign in_stall_o = stat.busy;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Append at the tail; drop terms once a store is full.
  assign we1 = in_fire && (in_data_i.action == spadd_pkg::ACT_APPEND_FIRST)
               && (cnt1_q < CW'(MAX_TERMS));
  assign we2 = in_fire && (in_data_i.action == spadd_pkg::ACT_APPEND_SECOND)
               && (cnt2_q < CW'(MAX_TERMS));
  assign wentry = {in_data_i.term_coeff, in_data_i.term_exponent};

  // A combine of two empty stores emits nothing and changes nothing.
  assign start = in_fire && (in_data_i.action == spadd_pkg::ACT_COMBINE)
                 && ((cnt1_q != '0) || (cnt2_q != '0));

  always_comb begin
    sub_mode_d = cfg_we_i ? cfg_wdata_i : sub_mode_q;
    cnt1_d     = cnt1_q;
    cnt2_d     = cnt2_q;
    if (stat.done) begin
      // Combine consumes both stores.
      cnt1_d = '0;
      cnt2_d = '0;
    end else begin
      if (we1) begin
        cnt1_d = cnt1_q + CW'(1);
      end
      if (we2) begin
        cnt2_d = cnt2_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_mode_q <= 1'b0;
      cnt1_q     <= '0;
      cnt2_q     <= '0;
    end else begin
      sub_mode_q <= sub_mode_d;
      cnt1_q     <= cnt1_d;
      cnt2_q     <= cnt2_d;
    end
  end

  spadd_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TERMS)
  ) u_ram_first (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (cnt1_q[AW-1:0]),
    .wdata_i (wentry),
    .raddr_i (raddr1),
    .rdata_o (rdata1)
  );

  spadd_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TERMS)
  ) u_ram_second (
    .clk_i   (clk_i),
    .we_i    (we2),
    .waddr_i (cnt2_q[AW-1:0]),
    .wdata_i (wentry),
    .raddr_i (raddr2),
    .rdata_o (rdata2)
  );

  spadd_merge #(
    .MAX_TERMS (MAX_TERMS)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .sub_mode_i     (sub_mode_q),
    .first_count_i  (cnt1_q),
    .second_count_i (cnt2_q),
    .first_rdata_i  (rdata1),
    .second_rdata_i (rdata2),
    .first_raddr_o  (raddr1),
    .second_raddr_o (raddr2),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

### src/spadd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module spadd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/spadd_merge.sv
// Merge engine: walks both stores by exponent, one result per cycle unless stalled.
// Depends on spadd_pkg; reads the term RAMs through their registered read ports.
module spadd_merge #(
  parameter int MAX_TERMS = spadd_pkg::MAX_TERMS,
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int CW = $clog2(MAX_TERMS + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                sub_mode_i,
  input  logic [CW-1:0]                       first_count_i,
  input  logic [CW-1:0]                       second_count_i,
  input  logic [spadd_pkg::ENTRY_BITS-1:0]    first_rdata_i,
  input  logic [spadd_pkg::ENTRY_BITS-1:0]    second_rdata_i,
  output logic [AW-1:0]                       first_raddr_o,
  output logic [AW-1:0]                       second_raddr_o,
  output spadd_pkg::merge_stat_t              stat_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output spadd_pkg::out_item_t                out_data_o
);

  localparam int EB = spadd_pkg::EXP_BITS;
  localparam int CB = spadd_pkg::COEFF_BITS;
  localparam int RB = spadd_pkg::RES_BITS;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  logic                 state_q, state_d;
  logic [CW-1:0]        i_q, i_d, j_q, j_d, i_inc, j_inc;
  logic                 out_valid_q, out_valid_d;
  spadd_pkg::out_item_t out_q, out_d;

  logic                 have1, have2, take1, take2, adv, last;
  logic [EB-1:0]        e1, e2;
  logic signed [CB-1:0] c1, c2;
  logic signed [RB-1:0] a, b, res;

  assign e1 = first_rdata_i[EB-1:0];
  assign e2 = second_rdata_i[EB-1:0];
  assign c1 = first_rdata_i[EB+CB-1:EB];
  assign c2 = second_rdata_i[EB+CB-1:EB];
  assign a  = {c1[CB-1], c1};
  assign b  = {c2[CB-1], c2};

  always_comb begin
    have1 = i_q < first_count_i;
    have2 = j_q < second_count_i;
    take1 = have1;
    take2 = have2;
    // Larger head exponent wins; equal heads combine.
    if (have1 && have2) begin
      if (e1 > e2) begin
        take2 = 1'b0;
      end else if (e1 < e2) begin
        take1 = 1'b0;
      end
    end
    if (take1 && take2) begin
      res = sub_mode_i ? (a - b) : (a + b);
    end else if (take1) begin
      res = a;
    end else begin
      res = sub_mode_i ? -b : b;
    end
  end

  assign adv   = (state_q == ST_MERGE) && (!out_valid_q || !out_stall_i);
  assign i_inc = i_q + CW'(take1);
  assign j_inc = j_q + CW'(take2);
  assign last  = (i_inc == first_count_i) && (j_inc == second_count_i);

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (adv) begin
          out_valid_d           = 1'b1;
          out_d.result_coeff    = res;
          out_d.result_exponent = take1 ? e1 : e2;
          out_d.last_term       = last;
          if (last) begin
            state_d = ST_IDLE;
            i_d     = '0;
            j_d     = '0;
          end else begin
            i_d = i_inc;
            j_d = j_inc;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Read the next heads while advancing, otherwise re-read the current ones.
  assign first_raddr_o  = adv ? i_d[AW-1:0] : i_q[AW-1:0];
  assign second_raddr_o = adv ? j_d[AW-1:0] : j_q[AW-1:0];

  assign stat_o.busy = (state_q == ST_MERGE);
  assign stat_o.done = adv && last;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### src/spadd_checker.sv
// Port-level checker for the sparse polynomial add/subtract unit, bound to the top.
// Depends on spadd_pkg and sparse_polynomial_add_sub_unit.
module spadd_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input spadd_pkg::in_item_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input spadd_pkg::out_item_t out_data_o
);

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Mid-run results keep the input side stalled.
  a_run_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_term |-> in_stall_o)
    else $error("input open while a merge run is unfinished");

  // Busy starts only after a combine transaction.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o
                                && in_data_i.action == spadd_pkg::ACT_COMBINE))
    else $error("stall raised without a combine");

  // Busy ends exactly when the final term is registered.
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o && out_data_o.last_term)
    else $error("merge ended without a last term");

endmodule

bind sparse_polynomial_add_sub_unit spadd_checker u_spadd_checker (.*);

### tb/tb_sparse_polynomial_add_sub_unit.sv
// Self-checking testbench for sparse_polynomial_add_sub_unit: loads term pairs,
// combines them and checks every merged term against an in-bench predictor.
// Depends on spadd_pkg and the unit's RTL; needs nothing else.
module tb_sparse_polynomial_add_sub_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import spadd_pkg::*;

  // Action code that the package leaves unnamed; the unit must ignore it.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic signed [COEFF_BITS-1:0] COEFF_MAX = {1'b0, {(COEFF_BITS-1){1'b1}}};
  localparam logic signed [COEFF_BITS-1:0] COEFF_MIN = {1'b1, {(COEFF_BITS-1){1'b0}}};
  localparam int EXP_MAX      = (1 << EXP_BITS) - 1;
  // A combine yields up to 2*MAX_TERMS result terms; leave margin on top of that.
  localparam int DRAIN_CYCLES = 2 * MAX_TERMS + 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_QUOTA  = 36;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_wdata_i = 1'b0;

  sparse_polynomial_add_sub_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: private copy of both term stores and the mode register.
  // ---------------------------------------------------------------------------
  logic signed [COEFF_BITS-1:0] poly_a_coeff [MAX_TERMS];
  logic        [EXP_BITS-1:0]   poly_a_exp   [MAX_TERMS];
  logic signed [COEFF_BITS-1:0] poly_b_coeff [MAX_TERMS];
  logic        [EXP_BITS-1:0]   poly_b_exp   [MAX_TERMS];
  int unsigned poly_a_len = 0;
  int unsigned poly_b_len = 0;
  logic        sub_mode   = 1'b0;

  out_item_t   expected_terms [$];
  in_item_t    pending_items  [$];

  int unsigned issued_n     = 0;  // transactions put on the input port
  int unsigned accepted_n   = 0;  // transactions the unit has taken
  int unsigned results_seen = 0;
  int unsigned mismatch_n   = 0;
  int unsigned cycle_n      = 0;

  // Generator-side bookkeeping, used only to size each phase.
  int unsigned gen_a_len     = 0;
  int unsigned gen_b_len     = 0;
  int unsigned counted_items = 0;

  // Sign-extend a stored coefficient to the result width.
  function automatic logic signed [RES_BITS-1:0] widen(logic signed [COEFF_BITS-1:0] c);
    return {c[COEFF_BITS-1], c};
  endfunction

  // Apply one accepted transaction to the predictor; a combine queues the
  // merged polynomial, larger head exponent first, last term flagged.
  task automatic merge_transaction(input in_item_t item);
    out_item_t   batch [$];
    out_item_t   term;
    int unsigned ia;
    int unsigned ib;
    bit          take_a;
    bit          take_b;
    ia = 0;
    ib = 0;
    case (item.action)
      ACT_APPEND_FIRST: begin
        if (poly_a_len < MAX_TERMS) begin
          poly_a_coeff[poly_a_len] = item.term_coeff;
          poly_a_exp[poly_a_len]   = item.term_exponent;
          poly_a_len++;
        end
      end
      ACT_APPEND_SECOND: begin
        if (poly_b_len < MAX_TERMS) begin
          poly_b_coeff[poly_b_len] = item.term_coeff;
          poly_b_exp[poly_b_len]   = item.term_exponent;
          poly_b_len++;
        end
      end
      ACT_COMBINE: begin
        while (ia < poly_a_len || ib < poly_b_len) begin
          take_a = ia < poly_a_len;
          take_b = ib < poly_b_len;
          // Take the head with the larger exponent; equal heads combine.
          if (take_a && take_b) begin
            if (poly_a_exp[ia] > poly_b_exp[ib]) take_b = 1'b0;
            else if (poly_a_exp[ia] < poly_b_exp[ib]) take_a = 1'b0;
          end
          term.last_term = 1'b0;
          if (take_a && take_b) begin
            term.result_coeff    = sub_mode ? widen(poly_a_coeff[ia]) - widen(poly_b_coeff[ib])
                                            : widen(poly_a_coeff[ia]) + widen(poly_b_coeff[ib]);
            term.result_exponent = poly_a_exp[ia];
            ia++;
            ib++;
          end else if (take_a) begin
            term.result_coeff    = widen(poly_a_coeff[ia]);
            term.result_exponent = poly_a_exp[ia];
            ia++;
          end else begin
            // Second-only terms flip sign when subtracting.
            term.result_coeff    = sub_mode ? -widen(poly_b_coeff[ib]) : widen(poly_b_coeff[ib]);
            term.result_exponent = poly_b_exp[ib];
            ib++;
          end
          batch.push_back(term);
        end
        if (batch.size() > 0) batch[batch.size()-1].last_term = 1'b1;
        foreach (batch[k]) expected_terms.push_back(batch[k]);
        poly_a_len = 0;
        poly_b_len = 0;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input side: count accepted transactions, feed the predictor, track mode.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sub_mode = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        merge_transaction(in_data_i);
        accepted_n++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: advance to the next pending item only once the current one has
  // been taken; work in bursts with random gaps in between.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || accepted_n == issued_n)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data_i  <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        issued_n++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(40, 1);
          gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: switch between stall styles at random intervals, and
  // once hold off for a long stretch so the unit backs up into its input.
  // ---------------------------------------------------------------------------
  int unsigned hold_left      = 0;
  bit          long_hold_done = 1'b0;
  int unsigned stall_style    = 0;
  int unsigned style_left     = 0;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!long_hold_done && results_seen >= 40) begin
      long_hold_done = 1'b1;
      hold_left      = 400;
      out_stall_i   <= 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(3, 0);
        style_left  = $urandom_range(120, 20);
      end else begin
        style_left--;
      end
      case (stall_style)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(3, 0) == 0);
        2:       out_stall_i <= ($urandom_range(3, 0) != 0);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every accepted result with the oldest expected term.
  // ---------------------------------------------------------------------------
  out_item_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_terms.size() == 0) begin
        mismatch_n++;
        if (mismatch_n <= 10)
          $display("unexpected term: coeff %0d exp %0d last %0b",
                   out_data_o.result_coeff, out_data_o.result_exponent, out_data_o.last_term);
      end else begin
        want = expected_terms.pop_front();
        if (out_data_o.result_coeff !== want.result_coeff ||
            out_data_o.result_exponent !== want.result_exponent ||
            out_data_o.last_term !== want.last_term) begin
          mismatch_n++;
          if (mismatch_n <= 10)
            $display({"term mismatch: expected coeff %0d exp %0d last %0b,",
                      " got coeff %0d exp %0d last %0b"},
                     want.result_coeff, want.result_exponent, want.last_term,
                     out_data_o.result_coeff, out_data_o.result_exponent, out_data_o.last_term);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_n++;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic [1:0] act,
                           input logic signed [COEFF_BITS-1:0] coeff,
                           input logic [EXP_BITS-1:0] expo);
    in_item_t item;
    item.action        = act;
    item.term_coeff    = coeff;
    item.term_exponent = expo;
    pending_items.push_back(item);
    // Count appends that fit and every combine.
    case (act)
      ACT_APPEND_FIRST:  if (gen_a_len < MAX_TERMS) begin gen_a_len++; counted_items++; end
      ACT_APPEND_SECOND: if (gen_b_len < MAX_TERMS) begin gen_b_len++; counted_items++; end
      ACT_COMBINE: begin
        gen_a_len = 0;
        gen_b_len = 0;
        counted_items++;
      end
      default: ;
    endcase
  endtask

  // Coefficients lean toward the extremes, zero and unit values.
  function automatic logic signed [COEFF_BITS-1:0] pick_coeff();
    case ($urandom_range(9, 0))
      0:       return COEFF_MAX;
      1:       return COEFF_MIN;
      2:       return '0;
      3:       return $urandom_range(1, 0) ? COEFF_BITS'(1) : COEFF_BITS'(-1);
      default: return COEFF_BITS'($urandom);
    endcase
  endfunction

  // Mostly small polynomials, a few large ones, rarely more than fit.
  function automatic int pick_size();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 67) return $urandom_range(6, 0);
    if (roll < 87) return $urandom_range(16, 7);
    if (roll < 97) return $urandom_range(MAX_TERMS, 17);
    return $urandom_range(MAX_TERMS + 4, MAX_TERMS + 1);
  endfunction

  // Load two polynomials, interleaving their appends at random, then combine.
  // Both walk down from the same top exponent so equal exponents are common;
  // with ordered clear the exponents are scrambled.
  task automatic queue_pair(input int n_a, input int n_b, input int top, input bit ordered);
    int cur [2];
    int left [2];
    int side;
    int step;
    cur[0]  = top;
    cur[1]  = top;
    left[0] = n_a;
    left[1] = n_b;
    while (left[0] + left[1] > 0) begin
      if (left[0] == 0) side = 1;
      else if (left[1] == 0) side = 0;
      else side = $urandom_range(1, 0);
      push_item(side ? ACT_APPEND_SECOND : ACT_APPEND_FIRST, pick_coeff(),
                ordered ? EXP_BITS'(cur[side]) : EXP_BITS'($urandom_range(EXP_MAX, 0)));
      left[side]--;
      step = $urandom_range(3, 1);
      if (cur[side] < step) left[side] = 0;
      else cur[side] -= step;
    end
    // Fields of a combine carry junk; the unit must ignore them.
    push_item(ACT_COMBINE, COEFF_BITS'($urandom), EXP_BITS'($urandom));
  endtask

  task automatic queue_random_phase(input bit with_overflow);
    int roll;
    counted_items = 0;
    if (with_overflow) begin
      // Overfill both stores, then fill both exactly for the longest combine.
      queue_pair(MAX_TERMS + 2, MAX_TERMS + 3, EXP_MAX, 1'b1);
      queue_pair(MAX_TERMS, MAX_TERMS, EXP_MAX, 1'b1);
    end
    while (counted_items < PHASE_QUOTA) begin
      roll = $urandom_range(99, 0);
      if (roll < 80)
        queue_pair(pick_size(), pick_size(), $urandom_range(EXP_MAX, 0), 1'b1);
      else if (roll < 88)
        queue_pair(pick_size(), pick_size(), $urandom_range(EXP_MAX, 0), 1'b0);
      else
        repeat ($urandom_range(6, 1))
          push_item(2'($urandom_range(3, 0)), COEFF_BITS'($urandom), EXP_BITS'($urandom));
    end
    push_item(ACT_COMBINE, '0, '0);
  endtask

  // Wait until the unit has taken everything and returned every expected term.
  task automatic wait_idle();
    while (pending_items.size() != 0 || accepted_n != issued_n || expected_terms.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, add mode.
    write_mode(1'b0);
    push_item(ACT_COMBINE, '0, '0);                  // both stores empty: no term
    push_item(ACT_UNUSED, COEFF_MAX, EXP_BITS'(EXP_MAX)); // ignored code
    push_item(ACT_APPEND_FIRST, COEFF_MAX, EXP_BITS'(EXP_MAX));
    push_item(ACT_APPEND_SECOND, COEFF_MAX, EXP_BITS'(EXP_MAX));
    push_item(ACT_APPEND_FIRST, COEFF_MIN, '0);
    push_item(ACT_APPEND_SECOND, COEFF_MIN, 8'd128);
    push_item(ACT_COMBINE, COEFF_MIN, EXP_BITS'(EXP_MAX));
    push_item(ACT_APPEND_FIRST, COEFF_BITS'(5), 8'd10);   // sum cancels to zero
    push_item(ACT_APPEND_SECOND, COEFF_BITS'(-5), 8'd10);
    push_item(ACT_COMBINE, '0, '0);
    push_item(ACT_APPEND_SECOND, COEFF_BITS'(1234), 8'd3); // second only, passes as is
    push_item(ACT_COMBINE, '0, '0);

    // Directed, subtract mode.
    write_mode(1'b1);
    push_item(ACT_APPEND_FIRST, COEFF_MIN, 8'd200);  // most negative difference
    push_item(ACT_APPEND_SECOND, COEFF_MAX, 8'd200);
    push_item(ACT_APPEND_SECOND, COEFF_MIN, 8'd7);   // negated minimum
    push_item(ACT_APPEND_FIRST, COEFF_BITS'(1), 8'd0);
    push_item(ACT_COMBINE, '0, '0);
    push_item(ACT_APPEND_SECOND, COEFF_BITS'(-1), EXP_BITS'(EXP_MAX));
    push_item(ACT_COMBINE, '0, '0);
    push_item(ACT_APPEND_FIRST, '0, '0);
    push_item(ACT_COMBINE, COEFF_MAX, EXP_BITS'(EXP_MAX));

    // Random phases, alternating the mode between them.
    queue_random_phase(1'b1);
    write_mode(1'b0);
    queue_random_phase(1'b0);
    write_mode(1'b1);
    queue_random_phase(1'b0);
    write_mode(1'b0);
    queue_random_phase(1'b1);
    write_mode(1'b1);
    queue_random_phase(1'b0);
    write_mode(1'b0);
    queue_random_phase(1'b0);

    wait_idle();
    if (mismatch_n == 0 && expected_terms.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
